@@ sv/iem_pkg.sv @@
package iem_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_DATA  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_REL, PH_ST_HIGH, PH_ST_LOW, PH_TX_LOW, PH_TX_HIGH,
        PH_AK_LOW, PH_AK_HIGH, PH_RX_LOW, PH_RX_HIGH, PH_MA_LOW, PH_MA_HIGH,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D, PH_WAIT
    } phase_t;

    typedef enum logic [3:0] {
        SQ_NONE, SQ_START, SQ_DEV, SQ_WORD, SQ_DATA, SQ_RESTART, SQ_DEVRD,
        SQ_RX, SQ_STOP, SQ_POLLACK, SQ_POLLSTART, SQ_POLLDEV
    } seq_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_START_ERR = 2'd1;
    localparam logic [1:0] ST_NACK      = 2'd2;

    localparam logic CFG_POLL_LIMIT = 1'b0;
    localparam logic CFG_DEV_ADDR   = 1'b1;

    // Decoded request as it travels from the front part to the engine.
    typedef struct packed {
        op_t        op;
        logic [7:0] mem_address;
        logic [8:0] byte_count;
        logic [7:0] data_byte;
        logic       sda_in;
        logic       write_enable;
    } req_t;

endpackage

@@ sv/iem_front.sv @@
module iem_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_data,
    output logic                q_valid,
    input  logic                q_ready,
    output iem_pkg::req_t       q_req
);
    import iem_pkg::*;

    // Two-entry queue decouples intake from the bus engine.
    req_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    req_t       dec;
    logic       push, pop;

    always_comb
    begin
        dec.op           = op_t'(in_data[1:0]);
        dec.mem_address  = in_data[9:2];
        dec.byte_count   = in_data[18:10];
        dec.data_byte    = in_data[26:19];
        dec.sda_in       = in_data[27];
        dec.write_enable = in_data[28];
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ sv/iem_engine.sv @@
module iem_engine #(
    parameter int MAX_TRANSFER = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  iem_pkg::req_t       q_req,
    input  logic [15:0]         poll_limit,
    input  logic [6:0]          device_address,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [16:0]         out_data
);
    import iem_pkg::*;

    localparam int CW = $clog2(MAX_TRANSFER + 1);

    phase_t      phase_reg, phase_next;
    seq_t        seq_reg, seq_next;
    kind_t       kind_reg, kind_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [CW-1:0] left_reg, left_next;
    logic [7:0]  waddr_reg, waddr_next;
    logic [15:0] poll_reg, poll_next;
    logic        scl_reg, scl_next, sda_reg, sda_next, wp_reg, wp_next;
    logic [1:0]  fstat_reg, fstat_next;
    logic        done, valid;
    logic [7:0]  got;
    logic        ovalid_reg;
    logic [16:0] odata_reg;
    logic        take;
    logic [CW-1:0] cnt_sat;
    logic [7:0]  addr_w;
    logic [CW-1:0] left_dec;

    assign q_ready   = !ovalid_reg || out_ready;
    assign take      = q_valid && q_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign addr_w    = {device_address, 1'b0};
    assign left_dec  = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    always_comb
    begin
        if ({{(32-9){1'b0}}, q_req.byte_count} > MAX_TRANSFER)
        begin
            cnt_sat = CW'(MAX_TRANSFER);
        end
        else
        begin
            cnt_sat = CW'(q_req.byte_count);
        end
    end

    always_comb
    begin
        phase_next = phase_reg; seq_next = seq_reg; kind_next = kind_reg;
        bit_next = bit_reg; shift_next = shift_reg; left_next = left_reg;
        waddr_next = waddr_reg; poll_next = poll_reg; fstat_next = fstat_reg;
        scl_next = scl_reg; sda_next = sda_reg; wp_next = wp_reg;
        done = 1'b0; valid = 1'b0; got = 8'd0;

        if (phase_reg == PH_IDLE)
        begin
            if (q_req.op == OP_WRITE || q_req.op == OP_READ)
            begin
                kind_next  = (q_req.op == OP_WRITE) ? KIND_WRITE : KIND_READ;
                waddr_next = q_req.mem_address;
                left_next  = cnt_sat;
                poll_next  = '0; fstat_next = ST_OK; bit_next = '0; shift_next = '0;
                wp_next    = !(q_req.op == OP_WRITE && q_req.write_enable);
                seq_next   = SQ_START;
                phase_next = PH_ST_REL;
            end
        end
        else
        begin
            case (phase_reg)
                PH_ST_REL: phase_next = PH_ST_HIGH;
                PH_ST_HIGH, PH_ST_LOW:
                begin
                    if ((phase_reg == PH_ST_HIGH) ? !q_req.sda_in : q_req.sda_in)
                    begin
                        if (seq_reg == SQ_RESTART)
                        begin
                            shift_next = addr_w | 8'h01; bit_next = '0;
                            seq_next = SQ_DEVRD; phase_next = PH_TX_LOW;
                        end
                        else
                        begin
                            fstat_next = ST_START_ERR; phase_next = PH_IDLE;
                            seq_next = SQ_NONE; wp_next = 1'b1; done = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_ST_HIGH)
                    begin
                        phase_next = PH_ST_LOW;
                    end
                    else
                    begin
                        bit_next = '0; phase_next = PH_TX_LOW;
                        if (seq_reg == SQ_RESTART)
                        begin
                            shift_next = addr_w | 8'h01; seq_next = SQ_DEVRD;
                        end
                        else if (seq_reg == SQ_POLLSTART)
                        begin
                            shift_next = addr_w; seq_next = SQ_POLLDEV;
                        end
                        else
                        begin
                            shift_next = addr_w; seq_next = SQ_DEV;
                        end
                    end
                end
                PH_TX_LOW: phase_next = PH_TX_HIGH;
                PH_TX_HIGH:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next = bit_reg + 4'd1;
                    if (bit_reg >= 4'd7)
                    begin
                        if (seq_reg == SQ_POLLDEV)
                        begin
                            seq_next = SQ_POLLACK;
                        end
                        phase_next = PH_AK_LOW;
                    end
                    else
                    begin
                        phase_next = PH_TX_LOW;
                    end
                end
                PH_AK_LOW: phase_next = PH_AK_HIGH;
                PH_AK_HIGH:
                begin
                    case (seq_reg)
                        SQ_DEV:
                        begin
                            if (q_req.sda_in)
                            begin
                                fstat_next = ST_NACK;
                                seq_next = SQ_STOP; phase_next = PH_SP_A;
                            end
                            else
                            begin
                                shift_next = waddr_reg; bit_next = '0;
                                seq_next = SQ_WORD; phase_next = PH_TX_LOW;
                            end
                        end
                        SQ_WORD:
                        begin
                            if (kind_reg == KIND_READ)
                            begin
                                seq_next = SQ_RESTART; phase_next = PH_ST_REL;
                            end
                            else if (left_reg == '0)
                            begin
                                seq_next = SQ_STOP; phase_next = PH_SP_A;
                            end
                            else
                            begin
                                seq_next = SQ_DATA; phase_next = PH_WAIT;
                            end
                        end
                        SQ_DATA:
                        begin
                            left_next = left_dec;
                            if (left_dec == '0)
                            begin
                                seq_next = SQ_STOP; phase_next = PH_SP_A;
                            end
                            else
                            begin
                                phase_next = PH_WAIT;
                            end
                        end
                        SQ_DEVRD:
                        begin
                            if (left_reg == '0)
                            begin
                                seq_next = SQ_STOP; phase_next = PH_SP_A;
                            end
                            else
                            begin
                                seq_next = SQ_RX; bit_next = '0; shift_next = '0;
                                phase_next = PH_RX_LOW;
                            end
                        end
                        default:
                        begin
                            if (!q_req.sda_in || poll_reg >= poll_limit)
                            begin
                                scl_next = 1'b0; fstat_next = ST_OK;
                                phase_next = PH_IDLE; seq_next = SQ_NONE;
                                wp_next = 1'b1; done = 1'b1;
                            end
                            else
                            begin
                                poll_next = poll_reg + 16'd1;
                                seq_next = SQ_POLLSTART; phase_next = PH_ST_REL;
                            end
                        end
                    endcase
                end
                PH_RX_LOW: phase_next = PH_RX_HIGH;
                PH_RX_HIGH:
                begin
                    shift_next = {shift_reg[6:0], q_req.sda_in};
                    bit_next = bit_reg + 4'd1;
                    if (bit_reg >= 4'd7)
                    begin
                        valid = 1'b1; got = shift_next; phase_next = PH_MA_LOW;
                    end
                    else
                    begin
                        phase_next = PH_RX_LOW;
                    end
                end
                PH_MA_LOW: phase_next = PH_MA_HIGH;
                PH_MA_HIGH:
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        seq_next = SQ_STOP; phase_next = PH_SP_A;
                    end
                    else
                    begin
                        seq_next = SQ_RX; bit_next = '0; shift_next = '0;
                        phase_next = PH_RX_LOW;
                    end
                end
                PH_SP_A: phase_next = PH_SP_B;
                PH_SP_B: phase_next = PH_SP_C;
                PH_SP_C: phase_next = PH_SP_D;
                PH_SP_D:
                begin
                    if (kind_reg == KIND_WRITE && fstat_reg == ST_OK)
                    begin
                        seq_next = SQ_POLLACK; phase_next = PH_AK_LOW;
                    end
                    else
                    begin
                        phase_next = PH_IDLE; seq_next = SQ_NONE;
                        wp_next = 1'b1; done = 1'b1;
                    end
                end
                PH_WAIT:
                begin
                    if (q_req.op == OP_DATA)
                    begin
                        shift_next = q_req.data_byte; bit_next = '0;
                        seq_next = SQ_DATA; phase_next = PH_TX_LOW;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end

        // Pin drive for the phase just entered.
        case (phase_next)
            PH_ST_REL: sda_next = 1'b1;
            PH_ST_HIGH:
            begin
                scl_next = 1'b1; sda_next = 1'b1;
            end
            PH_ST_LOW: sda_next = 1'b0;
            PH_TX_LOW:
            begin
                scl_next = 1'b0; sda_next = shift_next[7];
            end
            PH_AK_LOW, PH_RX_LOW:
            begin
                scl_next = 1'b0; sda_next = 1'b1;
            end
            PH_MA_LOW:
            begin
                scl_next = 1'b0; sda_next = (left_next == CW'(1));
            end
            PH_TX_HIGH, PH_AK_HIGH, PH_RX_HIGH, PH_MA_HIGH, PH_SP_C: scl_next = 1'b1;
            PH_SP_A: scl_next = 1'b0;
            PH_SP_B: sda_next = 1'b0;
            PH_SP_D: sda_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; seq_reg <= SQ_NONE; kind_reg <= KIND_NONE;
            bit_reg <= '0; shift_reg <= '0; left_reg <= '0; waddr_reg <= '0;
            poll_reg <= '0; fstat_reg <= ST_OK;
            scl_reg <= 1'b1; sda_reg <= 1'b1; wp_reg <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next; seq_reg <= seq_next; kind_reg <= kind_next;
                bit_reg <= bit_next; shift_reg <= shift_next; left_reg <= left_next;
                waddr_reg <= waddr_next; poll_reg <= poll_next;
                fstat_reg <= fstat_next;
                scl_reg <= scl_next; sda_reg <= sda_next; wp_reg <= wp_next;
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            odata_reg <= {(done ? fstat_next : 2'b00), done,
                          (phase_next != PH_IDLE), got, valid,
                          (phase_next == PH_WAIT), wp_next, sda_next, scl_next};
        end
    end
endmodule

@@ sv/i2c_eeprom_master.sv @@
// I2C master for a small serial EEPROM, driven one half-bit bus phase per
// input request. Each request on the s_axis channel (tdata fields, low bit up:
// operation, mem_address, byte_count, data_byte, sda_in, write_enable) yields
// exactly one result on m_axis (scl_level, sda_release, wp_level,
// data_request, read_valid, read_byte, busy_res, done_res, status).
// A two-entry queue takes requests in; the bus engine consumes one request
// per cycle while m_axis_tready is high and writes the result into an output
// register, so the block then sustains one request per clock. A result is shown
// the cycle after the engine takes its request; it can be taken at the following edge.
// If the receiver holds m_axis_tready low, the output register holds its
// result, the engine stops, and the queue fills and then drops s_axis_tready.
// Configuration writes (index 0 poll_limit, 1 device_address) go through
// cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write only when idle.
// Reset puts the engine idle with all lines released high, poll_limit 3200
// and device_address 80.
module i2c_eeprom_master #(
    parameter int MAX_TRANSFER = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], mem_address[9:2], byte_count[18:10], data_byte[26:19],
    // sda_in[27], write_enable[28], zero fill
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_level[0], sda_release[1], wp_level[2], data_request[3],
    // read_valid[4], read_byte[12:5], busy_res[13], done_res[14], status[16:15]
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import iem_pkg::*;

    logic        q_valid, q_ready;
    req_t        q_req;
    logic [15:0] poll_limit_reg;
    logic [6:0]  dev_addr_reg;
    logic [16:0] res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= 16'd3200;
            dev_addr_reg   <= 7'd80;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POLL_LIMIT: poll_limit_reg <= cfg_data;
                CFG_DEV_ADDR:   dev_addr_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    iem_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    iem_engine #(.MAX_TRANSFER(MAX_TRANSFER)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .poll_limit(poll_limit_reg), .device_address(dev_addr_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
    );

    assign m_axis_tdata = {7'd0, res};

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[14] |-> !m_axis_tdata[13])
        else $error("done reported while busy");
    a_wp_high_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[13] |-> m_axis_tdata[2])
        else $error("write protect low while idle");
    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[14] |-> m_axis_tdata[16:15] == 2'b00)
        else $error("status without done");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
`endif
endmodule
